FILE: rtl/gccc_pkg.sv
// shared types and constants for the gain constraint clamp cost block
package gccc_pkg;

  localparam int FracBits = 16;
  localparam logic [30:0] TimeStepReset = 31'd655;

  typedef enum logic [1:0] {
    CLAMP_INSIDE = 2'd0,
    CLAMP_BELOW  = 2'd1,
    CLAMP_ABOVE  = 2'd2
  } clamp_t;

  // input item
  typedef struct packed {
    logic signed [31:0] velocity;
    logic signed [31:0] gain;
    logic signed [31:0] bias;
    logic [30:0]        limit;
    logic               start_sum;
  } in_item_t;

  // result item
  typedef struct packed {
    logic signed [31:0] impulse;
    logic signed [31:0] hessian_diag;
    logic [1:0]         clamp_state;
    logic signed [63:0] running_cost;
  } out_item_t;

  // classified work handed from front to back
  typedef struct packed {
    logic signed [31:0] velocity;   // v
    logic signed [31:0] gain;       // k
    logic signed [48:0] y;          // floored y
    logic signed [31:0] c;          // clamped y
    logic signed [47:0] g;          // unsaturated impulse
    logic signed [31:0] impulse;
    logic signed [31:0] hessian_diag;
    logic [1:0]         clamp_state;
    logic               start_sum;
  } work_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_MUL  = 2'd1,
    BK_DIV  = 2'd2,
    BK_DONE = 2'd3
  } back_state_t;

endpackage

FILE: rtl/gccc_if.sv
// valid/ready channel interfaces for input and result items
interface gccc_in_if (input logic clk);
  import gccc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gccc_out_if (input logic clk);
  import gccc_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/gccc_front.sv
// front end: clamp, impulse and hessian, two registered stages
module gccc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic [30:0]         step_dt,
  input  logic                in_valid,
  output logic                in_ready,
  input  gccc_pkg::in_item_t  in_data,
  output logic                wk_valid,
  input  logic                wk_ready,
  output gccc_pkg::work_t     wk_data
);
  import gccc_pkg::*;

  // stage 1 registers
  logic               s1_valid;
  logic signed [31:0] s1_v, s1_k;
  logic signed [48:0] s1_y;
  logic signed [31:0] s1_c;
  logic [1:0]         s1_state;
  logic               s1_start;

  logic signed [64:0] bx, kv, yq;
  logic signed [48:0] y_fl;
  logic signed [32:0] e_pos, e_neg;
  logic               s1_take;

  // y = floor((b<<16 - k*v) / 2^16)
  assign bx   = 65'(in_data.bias) <<< FracBits;
  assign kv   = 65'(in_data.gain * in_data.velocity);
  assign yq   = bx - kv;
  assign y_fl = 49'(yq >>> FracBits);
  assign e_pos = {2'b00, in_data.limit};
  assign e_neg = -e_pos;

  logic s2_valid;
  logic s2_free;
  assign s2_free  = !s2_valid || wk_ready;
  assign in_ready = !s1_valid || s2_free;
  assign s1_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (s1_take) begin
      s1_v     <= in_data.velocity;
      s1_k     <= in_data.gain;
      s1_y     <= y_fl;
      s1_start <= in_data.start_sum;
      if (y_fl < 49'(e_neg)) begin
        s1_c     <= 32'(e_neg);
        s1_state <= CLAMP_BELOW;
      end else if (y_fl > 49'(e_pos)) begin
        s1_c     <= 32'(e_pos);
        s1_state <= CLAMP_ABOVE;
      end else begin
        s1_c     <= 32'(y_fl);
        s1_state <= CLAMP_INSIDE;
      end
    end
  end

  // stage 2: dt*c and dt*k products
  logic signed [63:0] pg, ph;
  logic signed [47:0] g_fl, h_fl;
  assign pg   = $signed({33'd0, step_dt}) * 64'(s1_c);
  assign ph   = $signed({33'd0, step_dt}) * 64'(s1_k);
  assign g_fl = 48'(pg >>> FracBits);
  assign h_fl = (s1_state == CLAMP_INSIDE) ? 48'(ph >>> FracBits) : 48'sd0;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
    if (x > 48'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (x < -48'sh80000000) return 32'sh80000000;
    return 32'(x);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
    if (s2_free && s1_valid) begin
      wk_data.velocity     <= s1_v;
      wk_data.gain         <= s1_k;
      wk_data.y            <= s1_y;
      wk_data.c            <= s1_c;
      wk_data.g            <= g_fl;
      wk_data.impulse      <= sat32(g_fl);
      wk_data.hessian_diag <= sat32(h_fl);
      wk_data.clamp_state  <= s1_state;
      wk_data.start_sum    <= s1_start;
    end
  end
  assign wk_valid = s2_valid;

  // a full stage 2 that is not drained keeps its contents
  a_hold: assert property (@(posedge clk) disable iff (rst)
    wk_valid && !wk_ready |=> wk_valid && $stable(wk_data))
    else $error("front stage lost held work");
  a_state: assert property (@(posedge clk) disable iff (rst)
    wk_valid && wk_data.clamp_state != CLAMP_INSIDE |-> wk_data.hessian_diag == 32'sd0)
    else $error("clamped item has hessian entry");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !in_ready |=> s1_valid)
    else $error("stage 1 dropped item");
endmodule

FILE: rtl/gccc_queue.sv
// two-entry queue between front and back
module gccc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  gccc_pkg::work_t wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output gccc_pkg::work_t rd_data
);
  import gccc_pkg::*;

  work_t      mem [2];
  logic       wp, rp;
  logic [1:0] count;
  logic       do_wr, do_rd;

  assign wr_ready = count != 2'd2;
  assign rd_valid = count != 2'd0;
  assign rd_data  = mem[rp];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_wr) wp <= ~wp;
      if (do_rd) rp <= ~rp;
      count <= count + 2'(do_wr) - 2'(do_rd);
    end
    if (do_wr) mem[wp] <= wr_data;
  end

  a_cnt: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count overflow");
  a_full: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 && !do_rd |=> count == 2'd2)
    else $error("queue full count changed");
  a_empty: assert property (@(posedge clk) disable iff (rst)
    count == 2'd0 && !do_wr |=> !rd_valid)
    else $error("queue produced from empty");
endmodule

FILE: rtl/gccc_back.sv
// back end: cost term by multiply and (positive gain only) bit-serial divide, saturating accumulate
module gccc_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                wk_valid,
  output logic                wk_ready,
  input  gccc_pkg::work_t     wk_data,
  output logic                out_valid,
  input  logic                out_ready,
  output gccc_pkg::out_item_t out_data
);
  import gccc_pkg::*;

  back_state_t state, state_next;
  work_t       cur;
  logic [63:0] pa, pb;         // magnitudes
  logic        neg;            // sign of term
  logic        pos_gain;
  logic [127:0] num;           // product, shifted out through the divider
  logic [63:0] dsor;
  logic [63:0] rem;
  logic [127:0] quo;
  logic [6:0]  bitcnt;
  logic        bitdone;
  logic [1:0]  mcnt;           // partial product index
  logic        mul_last;
  logic [31:0] ma, mb;
  logic [63:0] pp;
  logic [127:0] pp_sh;
  logic signed [63:0] acc;
  logic        res_valid;
  logic        out_load;
  logic signed [63:0] term;

  function automatic logic [63:0] mag(input logic signed [63:0] x);
    return x[63] ? 64'(-x) : 64'(x);
  endfunction

  // divide step: shift in one numerator bit, restore compare
  logic [64:0] rem_sh;
  logic        ge;
  assign rem_sh = {rem, num[127]};
  assign ge     = rem_sh >= {1'b0, dsor};
  assign bitdone = bitcnt == 7'd127;
  assign mul_last = mcnt == 2'd3;
  assign out_load = state == BK_DONE && (!res_valid || out_ready);

  // one 32x32 partial product per multiply cycle
  always_comb begin
    ma = mcnt[1] ? pa[63:32] : pa[31:0];
    mb = mcnt[0] ? pb[63:32] : pb[31:0];
    pp = ma * mb;
    case (mcnt)
      2'd0:    pp_sh = 128'(pp);
      2'd3:    pp_sh = 128'(pp) << 64;
      default: pp_sh = 128'(pp) << 32;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (wk_valid) state_next = BK_MUL;
      BK_MUL:  if (mul_last) state_next = pos_gain ? BK_DIV : BK_DONE;
      BK_DIV:  if (bitdone) state_next = BK_DONE;
      BK_DONE: if (!res_valid || out_ready) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    wk_ready = state == BK_IDLE;
  end

  // saturating 64-bit conversion of a 128-bit magnitude
  logic [127:0] mres;
  assign mres = pos_gain ? quo : (num >> FracBits);
  always_comb begin
    if (mres[127:63] != '0) term = neg ? 64'sh8000000000000000 : 64'sh7FFFFFFFFFFFFFFF;
    else term = neg ? -$signed(mres[63:0]) : $signed(mres[63:0]);
  end

  logic signed [63:0] acc_base;
  logic signed [64:0] acc_sum;
  logic signed [63:0] acc_new;
  assign acc_base = cur.start_sum ? 64'sd0 : acc;
  assign acc_sum  = 65'(acc_base) + 65'(term);
  assign acc_new  = (acc_sum[64] != acc_sum[63]) ?
                    (acc_sum[64] ? 64'sh8000000000000000 : 64'sh7FFFFFFFFFFFFFFF) :
                    acc_sum[63:0];

  logic signed [63:0] d_val, y64, c64;
  assign y64   = 64'(cur.y);
  assign c64   = 64'(cur.c);
  assign d_val = 2 * y64 - c64;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      acc       <= 64'sd0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        res_valid <= 1'b1;
        acc       <= acc_new;
      end else if (out_ready) begin
        res_valid <= 1'b0;
      end
    end
    case (state)
      BK_IDLE: begin
        if (wk_valid) begin
          cur      <= wk_data;
          pos_gain <= !wk_data.gain[31] && wk_data.gain != 32'sd0;
          num      <= '0;
          mcnt     <= '0;
        end
      end
      BK_MUL: begin
        num    <= num + pp_sh;
        mcnt   <= mcnt + 2'd1;
        rem    <= '0;
        quo    <= '0;
        bitcnt <= '0;
        dsor   <= {31'd0, cur.gain, 1'b0};
      end
      BK_DIV: begin
        rem    <= ge ? 64'(rem_sh - {1'b0, dsor}) : rem_sh[63:0];
        quo    <= {quo[126:0], ge};
        num    <= {num[126:0], 1'b0};
        bitcnt <= bitcnt + 7'd1;
      end
      BK_DONE: begin
        if (out_load) begin
          out_data.impulse      <= cur.impulse;
          out_data.hessian_diag <= cur.hessian_diag;
          out_data.clamp_state  <= cur.clamp_state;
          out_data.running_cost <= acc_new;
        end
      end
      default: ;
    endcase
  end

  // operand magnitudes and term sign
  logic signed [63:0] gsx, vsx, dsel;
  always_comb begin
    gsx  = 64'(cur.g);
    vsx  = 64'(cur.velocity);
    dsel = pos_gain ? d_val : vsx;
    pa   = mag(gsx);
    pb   = mag(dsel);
    neg  = pos_gain ? (gsx[63] != dsel[63]) : (gsx[63] == dsel[63]);
  end

  assign out_valid = res_valid;

  a_ready: assert property (@(posedge clk) disable iff (rst)
    wk_ready |-> state == BK_IDLE)
    else $error("back accepted while busy");
  a_div: assert property (@(posedge clk) disable iff (rst)
    state == BK_DIV |-> pos_gain)
    else $error("divide without positive gain");
  a_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
endmodule

FILE: rtl/gain_constraint_clamp_cost_top.sv
// top level of the gain constraint clamp cost block
//
//  channel    dir  payload
//  in_ch      in   velocity, gain, bias, limit, start_sum
//  out_ch     out  impulse, hessian_diag, clamp_state, running_cost
//  cfg        in   step_dt (write enable + data)
//
// the back end takes one item at a time: a partial-product multiply, then,
// with positive gain only, a bit-serial restoring divider.
// two front-end stages and a two-entry queue run ahead of the back end.
// rst is synchronous; it sets step_dt to 655 and clears the cost sum.
// a stalled result holds in the output register while the front keeps filling.
module gain_constraint_clamp_cost_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [30:0] cfg_wdata,
  gccc_in_if.sink     in_ch,
  gccc_out_if.source  out_ch
);
  import gccc_pkg::*;

  logic [30:0] step_dt;
  logic  f_valid, f_ready, q_valid, q_ready;
  work_t f_data, q_data;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) step_dt <= TimeStepReset;
    else if (cfg_we) step_dt <= cfg_wdata;
  end

  gccc_front u_front (
    .clk, .rst, .step_dt,
    .in_valid (in_ch.valid), .in_ready (in_ch.ready), .in_data (in_ch.data),
    .wk_valid (f_valid), .wk_ready (f_ready), .wk_data (f_data)
  );

  gccc_queue u_queue (
    .clk, .rst,
    .wr_valid (f_valid), .wr_ready (f_ready), .wr_data (f_data),
    .rd_valid (q_valid), .rd_ready (q_ready), .rd_data (q_data)
  );

  gccc_back u_back (
    .clk, .rst,
    .wk_valid (q_valid), .wk_ready (q_ready), .wk_data (q_data),
    .out_valid (out_ch.valid), .out_ready (out_ch.ready), .out_data (out_ch.data)
  );
endmodule
